[hdl/bcbem_pkg.sv]
// Package for the burst-checked byte-enable memory.
// It holds the shared types, field widths, error flag layout and lane mask helper.
// It depends on nothing else and is compiled first.
package bcbem_pkg;

	// Field widths that the bus fixes.
	localparam int ADDR_IN_W = 12;
	localparam int LEN_W = 7;
	localparam int BE_W = 16;
	localparam int HALF_W = 64;
	localparam int HALF_BYTES = 8;
	localparam int BYTE_W = 8;
	localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

	// Error flags, most significant first so that the packed value matches the bus.
	typedef struct packed {
		logic outside_burst;
		logic bad_start_type;
		logic start_in_burst;
		logic read_in_write_burst;
		logic write_in_read_burst;
		logic write_stall_change;
		logic read_stall_change;
	} err_flags_t;

	// Sequencer states of the top level.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_MERGE
	} state_t;

	// Expands eight byte enables into a mask over one 64-bit half word.
	function automatic logic [HALF_W-1:0] lane_mask(input logic [HALF_BYTES-1:0] enables);
		logic [HALF_W-1:0] m;
		m = '0;
		for (int i = 0; i < HALF_BYTES; i++) begin
			if (enables[i]) begin
				m[i*BYTE_W +: BYTE_W] = BYTE_MASK;
			end
		end
		return m;
	endfunction

endpackage

[hdl/bcbem_in_if.sv]
// Interface for the bus cycle channel into the memory slave.
// It depends on nothing; widths match the constants of bcbem_pkg.
interface bcbem_in_if;
	logic        valid;
	logic        ready;
	logic        read_request;
	logic        write_request;
	logic        burst_begin;
	logic [6:0]  burst_length;
	logic [11:0] word_address;
	logic [15:0] byte_enable;
	logic [63:0] write_low;
	logic [63:0] write_high;
	logic        ready_draw;

	modport source (
		output valid, read_request, write_request, burst_begin, burst_length,
		output word_address, byte_enable, write_low, write_high, ready_draw,
		input  ready
	);
	modport sink (
		input  valid, read_request, write_request, burst_begin, burst_length,
		input  word_address, byte_enable, write_low, write_high, ready_draw,
		output ready
	);
endinterface

[hdl/bcbem_out_if.sv]
// Interface for the result channel of the memory slave.
// It depends on nothing; widths match the constants of bcbem_pkg.
interface bcbem_out_if;
	logic        valid;
	logic        ready;
	logic        read_valid;
	logic [63:0] read_low;
	logic [63:0] read_high;
	logic        ready_now;
	logic [6:0]  error_flags;

	modport source (
		output valid, read_valid, read_low, read_high, ready_now, error_flags,
		input  ready
	);
	modport sink (
		input  valid, read_valid, read_low, read_high, ready_now, error_flags,
		output ready
	);
endinterface

[hdl/bcbem_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and held while read enable is low. No dependencies.
module bcbem_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/bcbem_burst.sv]
// Burst protocol checker and beat counter update for one bus cycle.
// Depends on bcbem_pkg for the error flag type and field widths.
module bcbem_burst #(
	parameter int MAX_BURST = 64
) (
	input  logic                         slave_ready,
	input  logic                         prev_read,
	input  logic                         prev_write,
	input  logic [$clog2(MAX_BURST)-1:0] beats_left,
	input  logic                         burst_is_read,
	input  logic                         read_request,
	input  logic                         write_request,
	input  logic                         burst_begin,
	input  logic [bcbem_pkg::LEN_W-1:0]  burst_length,
	output logic [$clog2(MAX_BURST)-1:0] beats_left_next,
	output logic                         burst_is_read_next,
	output bcbem_pkg::err_flags_t        errors
);

	localparam int BLW = $clog2(MAX_BURST);
	localparam int MW = $clog2(MAX_BURST + 1);
	localparam int LW = (MW > bcbem_pkg::LEN_W) ? MW : bcbem_pkg::LEN_W;

	logic [LW-1:0] len_ext;
	logic [LW-1:0] len_eff;

	// Zero length counts as one beat, overlong bursts saturate.
	always_comb begin
		len_ext = LW'(burst_length);
		if (len_ext == '0) begin
			len_eff = LW'(1);
		end else if (len_ext > LW'(MAX_BURST)) begin
			len_eff = LW'(MAX_BURST);
		end else begin
			len_eff = len_ext;
		end
	end

	// Protocol checks and the next burst state.
	always_comb begin
		beats_left_next = beats_left;
		burst_is_read_next = burst_is_read;
		errors = '0;
		if (!slave_ready) begin
			errors.read_stall_change = read_request != prev_read;
			errors.write_stall_change = write_request != prev_write;
		end else if (beats_left != '0) begin
			if (burst_is_read) begin
				if (read_request) begin
					beats_left_next = beats_left - BLW'(1);
				end
				errors.write_in_read_burst = write_request;
			end else begin
				if (write_request) begin
					beats_left_next = beats_left - BLW'(1);
				end
				errors.read_in_write_burst = read_request;
			end
			errors.start_in_burst = burst_begin;
		end else if (burst_begin) begin
			errors.bad_start_type = read_request == write_request;
			beats_left_next = BLW'(len_eff - LW'(1));
			burst_is_read_next = read_request;
		end else begin
			errors.outside_burst = read_request | write_request;
		end
	end

endmodule

[hdl/burst_checked_byte_enable_memory_top.sv]
// Burst-checked byte-enable memory slave, 128-bit words held as two 64-bit RAMs.
// Each transaction runs three steps: capture, RAM read, then merge and write back.
// The result is registered when the merge commits; a new transaction is accepted only
// after the read-modify-write through the registered RAM read has committed.
// Reset clears the burst state, the held read data and marks the slave not ready;
// RAM contents stay undefined until written, with no clearing pass.
module burst_checked_byte_enable_memory_top #(
	parameter int WORD_COUNT = 4096,
	parameter int MAX_BURST = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	bcbem_in_if.sink          item,
	bcbem_out_if.source       result
);

	localparam int AW = $clog2(WORD_COUNT);
	localparam int BLW = $clog2(MAX_BURST);
	localparam int HW = bcbem_pkg::HALF_W;
	localparam int HB = bcbem_pkg::HALF_BYTES;

	bcbem_pkg::state_t state_q, state_d;

	// Captured bus cycle.
	logic                            rd_q, wr_q, begin_q, draw_q;
	logic [bcbem_pkg::LEN_W-1:0]     len_q;
	logic [bcbem_pkg::ADDR_IN_W-1:0] addr_q;
	logic [bcbem_pkg::BE_W-1:0]      be_q;
	logic [HW-1:0]                   wlo_q, whi_q;
	logic [AW-1:0]                   raddr;
	logic [AW-1:0]                   addr_s2;

	// Burst and handshake state.
	logic [BLW-1:0]        beats_left_q, beats_left_d;
	logic                  burst_is_read_q, burst_is_read_d;
	logic                  slave_ready_q, prev_rd_q, prev_wr_q;
	logic [HW-1:0]         held_lo_q, held_hi_q;
	logic                  rd_valid_q, out_valid_q;
	bcbem_pkg::err_flags_t err_q, err_d;

	logic          accept, commit, ram_re, do_write;
	logic [HW-1:0] old_lo, old_hi, mask_lo, mask_hi, new_lo, new_hi;

	assign accept = item.valid & item.ready;
	assign ram_re = state_q == bcbem_pkg::ST_ISSUE;
	assign commit = (state_q == bcbem_pkg::ST_MERGE) & (~out_valid_q | result.ready);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcbem_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and input readiness.
	always_comb begin
		state_d = state_q;
		item.ready = 1'b0;
		unique case (state_q)
			bcbem_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					state_d = bcbem_pkg::ST_ISSUE;
				end
			end
			bcbem_pkg::ST_ISSUE: begin
				state_d = bcbem_pkg::ST_MERGE;
			end
			bcbem_pkg::ST_MERGE: begin
				if (commit) begin
					state_d = bcbem_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bcbem_pkg::ST_IDLE;
			end
		endcase
	end

	// Capture of the accepted transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= item.read_request;
			wr_q <= item.write_request;
			begin_q <= item.burst_begin;
			len_q <= item.burst_length;
			addr_q <= item.word_address;
			be_q <= item.byte_enable;
			wlo_q <= item.write_low;
			whi_q <= item.write_high;
			draw_q <= item.ready_draw;
		end
	end

	// Address reduction modulo the word count.
	generate
		if (WORD_COUNT >= (1 << bcbem_pkg::ADDR_IN_W)) begin : g_addr_wide
			assign raddr = AW'(addr_q);
		end else begin : g_addr_mod
			localparam int SH = 24;
			localparam longint RECIP = ((64'd1 << SH) + WORD_COUNT - 1) / WORD_COUNT;
			logic [31:0] quot_prod;
			logic [7:0]  quot_q;
			logic [19:0] quot_times;
			logic [bcbem_pkg::ADDR_IN_W-1:0] rem;

			// Quotient by reciprocal multiplication, registered at capture.
			assign quot_prod = 32'(item.word_address) * 32'(RECIP);
			always_ff @(posedge clk) begin
				if (accept) begin
					quot_q <= quot_prod[SH +: 8];
				end
			end

			// Remainder with one correction step.
			always_comb begin
				quot_times = 20'(quot_q) * 20'(WORD_COUNT);
				rem = addr_q - quot_times[bcbem_pkg::ADDR_IN_W-1:0];
				if (rem >= bcbem_pkg::ADDR_IN_W'(WORD_COUNT)) begin
					rem = rem - bcbem_pkg::ADDR_IN_W'(WORD_COUNT);
				end
			end
			assign raddr = AW'(rem);
		end
	endgenerate

	// Keep the reduced address for the write back.
	always_ff @(posedge clk) begin
		if (ram_re) begin
			addr_s2 <= raddr;
		end
	end

	// Word storage, low and high halves.
	bcbem_ram #(.WIDTH(HW), .DEPTH(WORD_COUNT)) u_ram_lo (
		.clk   (clk),
		.we    (commit & do_write),
		.waddr (addr_s2),
		.wdata (new_lo),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (old_lo)
	);

	bcbem_ram #(.WIDTH(HW), .DEPTH(WORD_COUNT)) u_ram_hi (
		.clk   (clk),
		.we    (commit & do_write),
		.waddr (addr_s2),
		.wdata (new_hi),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (old_hi)
	);

	// Byte merge; a read in the same cycle sees the written bytes.
	assign do_write = slave_ready_q & wr_q;
	assign mask_lo = bcbem_pkg::lane_mask(be_q[HB-1:0]);
	assign mask_hi = bcbem_pkg::lane_mask(be_q[2*HB-1:HB]);
	assign new_lo = do_write ? ((old_lo & ~mask_lo) | (wlo_q & mask_lo)) : old_lo;
	assign new_hi = do_write ? ((old_hi & ~mask_hi) | (whi_q & mask_hi)) : old_hi;

	// Burst protocol checks.
	bcbem_burst #(.MAX_BURST(MAX_BURST)) u_burst (
		.slave_ready        (slave_ready_q),
		.prev_read          (prev_rd_q),
		.prev_write         (prev_wr_q),
		.beats_left         (beats_left_q),
		.burst_is_read      (burst_is_read_q),
		.read_request       (rd_q),
		.write_request      (wr_q),
		.burst_begin        (begin_q),
		.burst_length       (len_q),
		.beats_left_next    (beats_left_d),
		.burst_is_read_next (burst_is_read_d),
		.errors             (err_d)
	);

	// State update and result register, loaded when the transaction commits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beats_left_q <= '0;
			burst_is_read_q <= 1'b0;
			slave_ready_q <= 1'b0;
			prev_rd_q <= 1'b0;
			prev_wr_q <= 1'b0;
			held_lo_q <= '0;
			held_hi_q <= '0;
			rd_valid_q <= 1'b0;
			err_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				if (slave_ready_q) begin
					beats_left_q <= beats_left_d;
					burst_is_read_q <= burst_is_read_d;
				end
				if (rd_q) begin
					held_lo_q <= new_lo;
					held_hi_q <= new_hi;
				end
				rd_valid_q <= rd_q & slave_ready_q;
				err_q <= err_d;
				prev_rd_q <= rd_q;
				prev_wr_q <= wr_q;
				slave_ready_q <= draw_q;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result channel.
	assign result.valid = out_valid_q;
	assign result.read_valid = rd_valid_q;
	assign result.read_low = held_lo_q;
	assign result.read_high = held_hi_q;
	assign result.ready_now = slave_ready_q;
	assign result.error_flags = err_q;

endmodule

[hdl/bcbem_checker.sv]
// Port-level checker for the burst-checked byte-enable memory.
// Depends only on the top level's ports; bound to the top level below.
module bcbem_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        read_valid,
	input logic [63:0] read_low,
	input logic [63:0] read_high,
	input logic        ready_now,
	input logic [6:0]  error_flags
);

	// A stalled result transaction keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_low) && $stable(read_high)
			&& $stable(read_valid) && $stable(ready_now) && $stable(error_flags))
		else $error("result changed while stalled");

	// Valid read data only comes from a ready cycle, which raises no stall flags.
	a_rv_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |-> error_flags[1:0] == 2'b00)
		else $error("stall flag on a valid read");

	// Stall flags exclude every burst flag.
	a_stall_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_flags[1:0] != 2'b00 |-> error_flags[6:2] == 5'b00000)
		else $error("stall and burst flags together");

	// An access outside a burst excludes the in-burst and start flags.
	a_outside_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_flags[6] |-> error_flags[5:0] == 6'b000000)
		else $error("outside-burst flag with other flags");

endmodule

bind burst_checked_byte_enable_memory_top bcbem_checker u_bcbem_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.read_valid  (result.read_valid),
	.read_low    (result.read_low),
	.read_high   (result.read_high),
	.ready_now   (result.ready_now),
	.error_flags (result.error_flags)
);
